// ----- rtl/core/bfti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfti_pkg: shared types, opcodes and microprogram of the tape interpreter
// Holds field widths, command and opcode codes, the control word layout,
// the microprogram store and the two dispatch tables used by the sequencer.
// ----------------------------------------------------------------------------
package bfti_pkg;

   // fixed payload widths
   localparam int CMD_W       = 2;
   localparam int PROG_ADDR_W = 10;
   localparam int BYTE_W      = 8;

   // request commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   // program characters
   localparam logic [BYTE_W-1:0] OP_HALT  = 8'h00;
   localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;

   // microprogram addresses
   typedef enum logic [4:0] {
      U_IDLE,
      U_WRITE,
      U_START,
      U_EXEC,
      U_INC,
      U_DEC,
      U_RIGHT,
      U_LEFT,
      U_OUT,
      U_IN,
      U_SKIP,
      U_OPEN,
      U_CLOSE,
      U_SCANF_RD,
      U_SCANF_CHK,
      U_SCANB_RD,
      U_SCANB_CHK,
      U_HALTCHK,
      U_RESP,
      U_CLEAR
   } upc_type;

   // program store read address source
   typedef enum logic [1:0] {
      RD_PC,
      RD_SCAN,
      RD_SCAN_DEC
   } rd_sel_type;

   // datapath action of one step
   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_CAPTURE,
      ACT_WRITE,
      ACT_START,
      ACT_INC,
      ACT_DEC,
      ACT_RIGHT,
      ACT_LEFT,
      ACT_OUT,
      ACT_IN,
      ACT_SKIP,
      ACT_OPEN,
      ACT_CLOSE,
      ACT_FWD_RD,
      ACT_FWD_CHK,
      ACT_BWD_RD,
      ACT_BWD_CHK,
      ACT_RESPOND,
      ACT_CLEAR
   } act_type;

   // branch condition of one step
   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_RSP_FREE,
      COND_CELL_ZERO,
      COND_CELL_NZ,
      COND_AT_END,
      COND_AT_ZERO,
      COND_FWD_STOP,
      COND_BWD_STOP,
      COND_CLEAR_DONE
   } cond_type;

   // where a taken branch goes
   typedef enum logic [1:0] {
      MODE_GOTO,
      MODE_CMD,
      MODE_OPC
   } mode_type;

   typedef struct packed {
      logic       req_ready;
      rd_sel_type rd_sel;
      act_type    act;
      cond_type   cond;
      mode_type   mode;
      upc_type    target;
      upc_type    fail;
   } ctrl_word_type;

   function automatic ctrl_word_type uword(logic rdy, rd_sel_type rd, act_type a,
                                           cond_type c, mode_type m,
                                           upc_type t, upc_type f);
      ctrl_word_type w;
      w.req_ready = rdy;
      w.rd_sel    = rd;
      w.act       = a;
      w.cond      = c;
      w.mode      = m;
      w.target    = t;
      w.fail      = f;
      return w;
   endfunction

   // microprogram store
   function automatic ctrl_word_type ucode_rom(upc_type u);
      ctrl_word_type w;
      case (u)
         U_IDLE:      w = uword(1'b1, RD_PC, ACT_CAPTURE, COND_ACCEPT, MODE_CMD,
                                U_IDLE, U_IDLE);
         U_WRITE:     w = uword(1'b0, RD_PC, ACT_WRITE, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_START:     w = uword(1'b0, RD_PC, ACT_START, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_EXEC:      w = uword(1'b0, RD_PC, ACT_NONE, COND_ALWAYS, MODE_OPC,
                                U_HALTCHK, U_HALTCHK);
         U_INC:       w = uword(1'b0, RD_PC, ACT_INC, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_DEC:       w = uword(1'b0, RD_PC, ACT_DEC, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_RIGHT:     w = uword(1'b0, RD_PC, ACT_RIGHT, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_LEFT:      w = uword(1'b0, RD_PC, ACT_LEFT, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_OUT:       w = uword(1'b0, RD_PC, ACT_OUT, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_IN:        w = uword(1'b0, RD_PC, ACT_IN, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_SKIP:      w = uword(1'b0, RD_PC, ACT_SKIP, COND_ALWAYS, MODE_GOTO,
                                U_HALTCHK, U_HALTCHK);
         U_OPEN:      w = uword(1'b0, RD_PC, ACT_OPEN, COND_CELL_ZERO, MODE_GOTO,
                                U_SCANF_RD, U_HALTCHK);
         U_CLOSE:     w = uword(1'b0, RD_PC, ACT_CLOSE, COND_CELL_NZ, MODE_GOTO,
                                U_SCANB_RD, U_HALTCHK);
         U_SCANF_RD:  w = uword(1'b0, RD_SCAN, ACT_FWD_RD, COND_AT_END, MODE_GOTO,
                                U_HALTCHK, U_SCANF_CHK);
         U_SCANF_CHK: w = uword(1'b0, RD_PC, ACT_FWD_CHK, COND_FWD_STOP, MODE_GOTO,
                                U_HALTCHK, U_SCANF_RD);
         U_SCANB_RD:  w = uword(1'b0, RD_SCAN_DEC, ACT_BWD_RD, COND_AT_ZERO,
                                MODE_GOTO, U_HALTCHK, U_SCANB_CHK);
         U_SCANB_CHK: w = uword(1'b0, RD_PC, ACT_BWD_CHK, COND_BWD_STOP, MODE_GOTO,
                                U_HALTCHK, U_SCANB_RD);
         U_HALTCHK:   w = uword(1'b0, RD_PC, ACT_NONE, COND_ALWAYS, MODE_GOTO,
                                U_RESP, U_RESP);
         U_RESP:      w = uword(1'b0, RD_PC, ACT_RESPOND, COND_RSP_FREE, MODE_GOTO,
                                U_IDLE, U_RESP);
         U_CLEAR:     w = uword(1'b0, RD_PC, ACT_CLEAR, COND_CLEAR_DONE, MODE_GOTO,
                                U_IDLE, U_CLEAR);
         default:     w = uword(1'b0, RD_PC, ACT_NONE, COND_ALWAYS, MODE_GOTO,
                                U_IDLE, U_IDLE);
      endcase
      return w;
   endfunction

   // command dispatch, unused command only reports
   function automatic upc_type cmd_entry(logic [CMD_W-1:0] cmd);
      upc_type u;
      case (cmd)
         CMD_WRITE: u = U_WRITE;
         CMD_STEP:  u = U_EXEC;
         CMD_START: u = U_START;
         default:   u = U_HALTCHK;
      endcase
      return u;
   endfunction

   // opcode dispatch, zero byte halts, unknown bytes skip
   function automatic upc_type opc_entry(logic [BYTE_W-1:0] op);
      upc_type u;
      case (op)
         OP_HALT:  u = U_HALTCHK;
         OP_INC:   u = U_INC;
         OP_DEC:   u = U_DEC;
         OP_RIGHT: u = U_RIGHT;
         OP_LEFT:  u = U_LEFT;
         OP_OPEN:  u = U_OPEN;
         OP_CLOSE: u = U_CLOSE;
         OP_OUT:   u = U_OUT;
         OP_IN:    u = U_IN;
         default:  u = U_SKIP;
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bfti_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfti_if: request and response channels of the tape interpreter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bfti_req_if import bfti_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [PROG_ADDR_W-1:0] prog_addr;
   logic [BYTE_W-1:0]      prog_byte;
   logic [BYTE_W-1:0]      in_byte;
   logic                   in_present;

   modport source (output valid, command, prog_addr, prog_byte, in_byte, in_present,
                   input ready);
   modport sink (input valid, command, prog_addr, prog_byte, in_byte, in_present,
                 output ready);
endinterface

interface bfti_rsp_if import bfti_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   out_valid;
   logic [BYTE_W-1:0]      out_byte;
   logic                   took_input;
   logic                   halted;
   logic [PROG_ADDR_W-1:0] next_pc;

   modport source (output valid, out_valid, out_byte, took_input, halted, next_pc,
                   input ready);
   modport sink (input valid, out_valid, out_byte, took_input, halted, next_pc,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bf_tape_interpreter_unit.sv -----
`default_nettype none
// A write or restart runs its action, the halt check and the response step; a
// simple step puts the opcode dispatch first; a halted step and an unused command
// go to the halt check from dispatch or from idle. Bracket scans alternate a read
// and a check step per program byte. Throughput: one item at a time, one microstep
// per cycle over one store read port. Reset (synchronous) clears the tape and the
// program store over max(TAPE_CELLS, PROGRAM_BYTES) addresses, taking no request.
// ----------------------------------------------------------------------------
// bf_tape_interpreter_unit: microcoded tape machine for the eight-symbol language
// A step counter walks a read-only microprogram; each control word selects a
// store read address, a datapath action and a conditional branch.
// ----------------------------------------------------------------------------
module bf_tape_interpreter_unit import bfti_pkg::*; #(
   parameter int TAPE_CELLS    = 4096,
   parameter int PROGRAM_BYTES = 1024
) (
   input  wire              clock,
   input  wire              reset,
   bfti_req_if.sink         req_chan,
   bfti_rsp_if.source       rsp_chan
);

   localparam int CP_W       = $clog2(TAPE_CELLS);
   localparam int PC_W       = $clog2(PROGRAM_BYTES);
   localparam int AW         = $clog2(PROGRAM_BYTES + 1);
   localparam int CLR_CELLS  = (TAPE_CELLS > PROGRAM_BYTES) ? TAPE_CELLS : PROGRAM_BYTES;
   localparam int CLR_W      = $clog2(CLR_CELLS);
   localparam int ADDR_SPAN  = 1 << PROG_ADDR_W;
   localparam int MOD_STEPS  = (PROGRAM_BYTES >= ADDR_SPAN) ? 0 :
                               $clog2((ADDR_SPAN + PROGRAM_BYTES - 1) / PROGRAM_BYTES);

   // request address folded into the store, by binary conditional subtraction
   function automatic logic [PC_W-1:0] wrap_addr(logic [PROG_ADDR_W-1:0] a);
      logic [PROG_ADDR_W-1:0] v;
      v = a;
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if ({1'b0, v} >= (PROG_ADDR_W+1)'(PROGRAM_BYTES << k)) begin
            v = v - PROG_ADDR_W'(PROGRAM_BYTES << k);
         end
      end
      return PC_W'(v);
   endfunction

   // memories
   logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
   logic [BYTE_W-1:0] prog_mem [PROGRAM_BYTES];

   // sequencer and datapath registers
   upc_type           upc_ff, upc_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [CP_W-1:0]   cp_ff, cp_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     depth_ff, depth_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [BYTE_W-1:0] prog_rd_ff, tape_rd_ff;
   logic [PC_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [BYTE_W-1:0] wr_byte_ff, wr_byte_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_present_ff, in_present_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              took_ff, took_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_out_valid_ff, rsp_out_valid_in;
   logic [BYTE_W-1:0]      rsp_out_byte_ff, rsp_out_byte_in;
   logic                   rsp_took_ff, rsp_took_in;
   logic                   rsp_halted_ff, rsp_halted_in;
   logic [PROG_ADDR_W-1:0] rsp_pc_ff, rsp_pc_in;

   ctrl_word_type     ctrl;
   logic              req_xfer;
   logic              rsp_free;
   logic              cond_true;
   logic [PC_W-1:0]   pc_inc;
   logic [PC_W-1:0]   scan_lo;
   logic [PC_W-1:0]   scan_inc;
   logic [AW-1:0]     addr_dec;
   logic              at_end;
   logic              at_zero;
   logic              depth_one;
   logic              fwd_stop;
   logic              bwd_stop;
   logic              clear_done;
   logic [PC_W-1:0]   prog_raddr;
   logic              prog_we;
   logic [PC_W-1:0]   prog_waddr;
   logic [BYTE_W-1:0] prog_wdata;
   logic              tape_we;
   logic [CP_W-1:0]   tape_waddr;
   logic [BYTE_W-1:0] tape_wdata;

   // control word of the current step
   always_comb begin
      ctrl = ucode_rom(upc_ff);
   end

   assign req_chan.ready = ctrl.req_ready;
   assign req_xfer       = req_chan.valid && ctrl.req_ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // status seen by the branch logic
   assign pc_inc     = (pc_ff == PC_W'(PROGRAM_BYTES - 1)) ? '0 : pc_ff + 1'b1;
   assign scan_lo    = addr_ff[PC_W-1:0];
   assign scan_inc   = (scan_lo == PC_W'(PROGRAM_BYTES - 1)) ? '0 : scan_lo + 1'b1;
   assign addr_dec   = addr_ff - 1'b1;
   assign at_end     = (addr_ff == AW'(PROGRAM_BYTES));
   assign at_zero    = (addr_ff == '0);
   assign depth_one  = (depth_ff == AW'(1));
   assign fwd_stop   = (prog_rd_ff == OP_HALT) || ((prog_rd_ff == OP_CLOSE) && depth_one);
   assign bwd_stop   = (prog_rd_ff == OP_OPEN) && depth_one;
   assign clear_done = (clr_ff == CLR_W'(CLR_CELLS - 1));

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_ACCEPT:     cond_true = req_xfer;
         COND_RSP_FREE:   cond_true = rsp_free;
         COND_CELL_ZERO:  cond_true = (tape_rd_ff == '0);
         COND_CELL_NZ:    cond_true = (tape_rd_ff != '0);
         COND_AT_END:     cond_true = at_end;
         COND_AT_ZERO:    cond_true = at_zero;
         COND_FWD_STOP:   cond_true = fwd_stop;
         COND_BWD_STOP:   cond_true = bwd_stop;
         COND_CLEAR_DONE: cond_true = clear_done;
         default:         cond_true = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      upc_in = ctrl.fail;
      if (cond_true) begin
         case (ctrl.mode)
            MODE_GOTO: upc_in = ctrl.target;
            MODE_CMD:  upc_in = cmd_entry(req_chan.command);
            MODE_OPC:  upc_in = opc_entry(prog_rd_ff);
            default:   upc_in = ctrl.target;
         endcase
      end
   end

   // program store read address
   always_comb begin
      case (ctrl.rd_sel)
         RD_PC:       prog_raddr = pc_ff;
         RD_SCAN:     prog_raddr = scan_lo;
         RD_SCAN_DEC: prog_raddr = addr_dec[PC_W-1:0];
         default:     prog_raddr = pc_ff;
      endcase
   end

   // datapath actions
   always_comb begin
      pc_in         = pc_ff;
      cp_in         = cp_ff;
      addr_in       = addr_ff;
      depth_in      = depth_ff;
      clr_in        = clr_ff;
      wr_addr_in    = wr_addr_ff;
      wr_byte_in    = wr_byte_ff;
      in_byte_in    = in_byte_ff;
      in_present_in = in_present_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      took_in       = took_ff;
      prog_we       = 1'b0;
      prog_waddr    = wr_addr_ff;
      prog_wdata    = wr_byte_ff;
      tape_we       = 1'b0;
      tape_waddr    = cp_ff;
      tape_wdata    = tape_rd_ff;
      case (ctrl.act)
         ACT_NONE: begin
         end
         ACT_CAPTURE: begin
            if (req_xfer) begin
               wr_addr_in    = wrap_addr(req_chan.prog_addr);
               wr_byte_in    = req_chan.prog_byte;
               in_byte_in    = req_chan.in_byte;
               in_present_in = req_chan.in_present;
               out_valid_in  = 1'b0;
               out_byte_in   = '0;
               took_in       = 1'b0;
            end
         end
         ACT_WRITE: begin
            prog_we = 1'b1;
         end
         ACT_START: begin
            pc_in = '0;
         end
         ACT_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rd_ff + 1'b1;
            pc_in      = pc_inc;
         end
         ACT_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rd_ff - 1'b1;
            pc_in      = pc_inc;
         end
         ACT_RIGHT: begin
            cp_in = (cp_ff == CP_W'(TAPE_CELLS - 1)) ? '0 : cp_ff + 1'b1;
            pc_in = pc_inc;
         end
         ACT_LEFT: begin
            cp_in = (cp_ff == '0) ? CP_W'(TAPE_CELLS - 1) : cp_ff - 1'b1;
            pc_in = pc_inc;
         end
         ACT_OUT: begin
            out_valid_in = 1'b1;
            out_byte_in  = tape_rd_ff;
            pc_in        = pc_inc;
         end
         ACT_IN: begin
            tape_we    = 1'b1;
            tape_wdata = in_present_ff ? in_byte_ff : '0;
            took_in    = in_present_ff;
            pc_in      = pc_inc;
         end
         ACT_SKIP: begin
            pc_in = pc_inc;
         end
         ACT_OPEN: begin
            // scan starts one past the open bracket
            addr_in  = AW'(pc_ff) + 1'b1;
            depth_in = AW'(1);
            pc_in    = pc_inc;
         end
         ACT_CLOSE: begin
            // fall-through target doubles as the unmatched result
            addr_in  = AW'(pc_ff);
            depth_in = AW'(1);
            pc_in    = pc_inc;
         end
         ACT_FWD_RD: begin
            if (at_end) begin
               pc_in = '0;
            end
         end
         ACT_FWD_CHK: begin
            if (prog_rd_ff == OP_HALT) begin
               pc_in = scan_lo;
            end else if (prog_rd_ff == OP_OPEN) begin
               depth_in = depth_ff + 1'b1;
            end else if (prog_rd_ff == OP_CLOSE) begin
               if (depth_one) begin
                  pc_in = scan_inc;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
            end
            addr_in = addr_ff + 1'b1;
         end
         ACT_BWD_RD: begin
            if (!at_zero) begin
               addr_in = addr_dec;
            end
         end
         ACT_BWD_CHK: begin
            if (prog_rd_ff == OP_CLOSE) begin
               depth_in = depth_ff + 1'b1;
            end else if (prog_rd_ff == OP_OPEN) begin
               if (depth_one) begin
                  pc_in = scan_lo;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
            end
         end
         ACT_RESPOND: begin
         end
         ACT_CLEAR: begin
            tape_we    = ({1'b0, clr_ff} < (CLR_W+1)'(TAPE_CELLS));
            tape_waddr = CP_W'(clr_ff);
            tape_wdata = '0;
            prog_we    = ({1'b0, clr_ff} < (CLR_W+1)'(PROGRAM_BYTES));
            prog_waddr = PC_W'(clr_ff);
            prog_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // response register, refilled as soon as the slot frees
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_took_in      = rsp_took_ff;
      rsp_halted_in    = rsp_halted_ff;
      rsp_pc_in        = rsp_pc_ff;
      if (ctrl.act == ACT_RESPOND && rsp_free) begin
         rsp_valid_in     = 1'b1;
         rsp_out_valid_in = out_valid_ff;
         rsp_out_byte_in  = out_byte_ff;
         rsp_took_in      = took_ff;
         rsp_halted_in    = (prog_rd_ff == OP_HALT);
         rsp_pc_in        = PROG_ADDR_W'(pc_ff);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_valid  = rsp_out_valid_ff;
   assign rsp_chan.out_byte   = rsp_out_byte_ff;
   assign rsp_chan.took_input = rsp_took_ff;
   assign rsp_chan.halted     = rsp_halted_ff;
   assign rsp_chan.next_pc    = rsp_pc_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= U_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         cp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         cp_ff        <= cp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff          <= addr_in;
      depth_ff         <= depth_in;
      wr_addr_ff       <= wr_addr_in;
      wr_byte_ff       <= wr_byte_in;
      in_byte_ff       <= in_byte_in;
      in_present_ff    <= in_present_in;
      out_valid_ff     <= out_valid_in;
      out_byte_ff      <= out_byte_in;
      took_ff          <= took_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_took_ff      <= rsp_took_in;
      rsp_halted_ff    <= rsp_halted_in;
      rsp_pc_ff        <= rsp_pc_in;
   end

   // program store, one write and one registered read
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= prog_wdata;
      end
      prog_rd_ff <= prog_mem[prog_raddr];
   end

   // tape, read at the cell pointer every cycle
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      tape_rd_ff <= tape_mem[cp_ff];
   end

`ifndef SYNTHESIS
   pc_range_a: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pc_ff} < (PC_W+1)'(PROGRAM_BYTES))
      else $error("program counter beyond program store");

   cp_range_a: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cp_ff} < (CP_W+1)'(TAPE_CELLS))
      else $error("cell pointer beyond tape");

   clear_block_a: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_CLEAR) |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   depth_live_a: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_SCANF_CHK || upc_ff == U_SCANB_CHK) |-> (depth_ff != '0))
      else $error("bracket depth reached zero inside a scan");

   respond_a: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_RESP && rsp_free) |=> (rsp_chan.valid && upc_ff == U_IDLE))
      else $error("response step did not load the response register");
`endif

endmodule
`default_nettype wire

// ----- tb/bf_tape_interpreter_unit_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bf_tape_interpreter_unit_test: self-checking bench for the tape interpreter
// Drives program writes, steps, restarts and unused commands over the request
// channel. Every transfer is run through a local model of the tape machine, and
// each response is compared with the oldest outstanding prediction. A directed
// script comes first, then random programs with noise, then a pass over the
// whole store that exercises long bracket scans and program counter wrap.
// ----------------------------------------------------------------------------
module bf_tape_interpreter_unit_test;
   import bfti_pkg::*;

   localparam int TAPE_CELLS    = 4096;
   localparam int PROGRAM_BYTES = 1024;
   localparam int RANDOM_ITEMS  = 160;
   localparam int CYCLE_LIMIT   = 10000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [BYTE_W-1:0] OTHER_BYTE = 8'hFF;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [PROG_ADDR_W-1:0] prog_addr;
      logic [BYTE_W-1:0]      prog_byte;
      logic [BYTE_W-1:0]      in_byte;
      logic                   in_present;
   } tape_req_type;

   typedef struct packed {
      logic                   out_valid;
      logic [BYTE_W-1:0]      out_byte;
      logic                   took_input;
      logic                   halted;
      logic [PROG_ADDR_W-1:0] next_pc;
   } tape_rsp_type;

   typedef struct {
      tape_req_type req;
      bit           typed;
      tape_rsp_type want;
   } script_row_type;

   localparam tape_rsp_type NO_RSP = '0;

   logic clock;
   logic reset;

   bfti_req_if req_chan ();
   bfti_rsp_if rsp_chan ();

   bf_tape_interpreter_unit #(
      .TAPE_CELLS    (TAPE_CELLS),
      .PROGRAM_BYTES (PROGRAM_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // machine state as the bench sees it
   logic [BYTE_W-1:0]      tape_mem [TAPE_CELLS];
   logic [BYTE_W-1:0]      prog_mem [PROGRAM_BYTES];
   logic [11:0]            cell_ptr;
   logic [PROG_ADDR_W-1:0] prog_ctr;

   tape_rsp_type   due_reports [$];
   script_row_type script [$];
   int             idle_odds;
   int             items_done;
   int             mismatch_count;
   int             cycle_count;
   tape_rsp_type   got_rsp;
   tape_rsp_type   want_rsp;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // forward bracket search: stops after the matching close, on a zero byte,
   // or wraps to address zero at the end of the store
   function automatic logic [PROG_ADDR_W-1:0] seek_close(input logic [PROG_ADDR_W-1:0] from);
      int depth;
      int p;
      depth = 1;
      for (p = int'(from) + 1; p < PROGRAM_BYTES; p++) begin
         if (prog_mem[p] == OP_HALT)
            return 10'(p);
         if (prog_mem[p] == OP_OPEN)
            depth++;
         else if (prog_mem[p] == OP_CLOSE) begin
            depth--;
            if (depth == 0)
               return 10'(p + 1);
         end
      end
      return '0;
   endfunction

   // backward bracket search: lands on the matching open, or falls through
   function automatic logic [PROG_ADDR_W-1:0] seek_open(input logic [PROG_ADDR_W-1:0] from);
      int depth;
      int p;
      depth = 1;
      for (p = int'(from) - 1; p >= 0; p--) begin
         if (prog_mem[p] == OP_CLOSE)
            depth++;
         else if (prog_mem[p] == OP_OPEN) begin
            depth--;
            if (depth == 0)
               return 10'(p);
         end
      end
      return from + 1'b1;
   endfunction

   // apply one request to the machine state and report what it gives
   task automatic interpret_item(input tape_req_type it, output tape_rsp_type r);
      logic [PROG_ADDR_W-1:0] pc_now;
      logic [PROG_ADDR_W-1:0] pc_new;
      logic [BYTE_W-1:0]      op;
      r = '0;
      pc_now = prog_ctr;
      case (it.cmd)
         CMD_WRITE: prog_mem[it.prog_addr] = it.prog_byte;
         CMD_START: pc_now = '0;
         CMD_STEP: begin
            op = prog_mem[pc_now];
            if (op != OP_HALT) begin
               pc_new = pc_now + 1'b1;
               case (op)
                  OP_INC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] + 1'b1;
                  OP_DEC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] - 1'b1;
                  OP_RIGHT: cell_ptr = cell_ptr + 1'b1;
                  OP_LEFT:  cell_ptr = cell_ptr - 1'b1;
                  OP_OPEN: begin
                     if (tape_mem[cell_ptr] == '0)
                        pc_new = seek_close(pc_now);
                  end
                  OP_CLOSE: begin
                     if (tape_mem[cell_ptr] != '0)
                        pc_new = seek_open(pc_now);
                  end
                  OP_OUT: begin
                     r.out_valid = 1'b1;
                     r.out_byte  = tape_mem[cell_ptr];
                  end
                  OP_IN: begin
                     tape_mem[cell_ptr] = it.in_present ? it.in_byte : '0;
                     r.took_input = it.in_present;
                  end
                  default: ;
               endcase
               pc_now = pc_new;
            end
         end
         default: ;
      endcase
      prog_ctr  = pc_now;
      r.halted  = (prog_mem[pc_now] == OP_HALT);
      r.next_pc = pc_now;
   endtask

   // one request transfer, with an optional idle burst in front
   task automatic send_item(input tape_req_type it, input bit typed, input tape_rsp_type want);
      tape_rsp_type r;
      int gap;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.command    = it.cmd;
      req_chan.prog_addr  = it.prog_addr;
      req_chan.prog_byte  = it.prog_byte;
      req_chan.in_byte    = it.in_byte;
      req_chan.in_present = it.in_present;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      interpret_item(it, r);
      due_reports.push_back(typed ? want : r);
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [PROG_ADDR_W-1:0] addr,
                        input logic [BYTE_W-1:0] pbyte, input logic present);
      tape_req_type it;
      it = {cmd, addr, pbyte, 8'($urandom), present};
      send_item(it, 1'b0, NO_RSP);
      if (cmd != CMD_UNUSED)
         items_done++;
   endtask

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [PROG_ADDR_W-1:0] addr,
                          input logic [BYTE_W-1:0] pbyte, input logic [BYTE_W-1:0] ibyte,
                          input logic present, input bit typed, input tape_rsp_type want);
      script_row_type row;
      row.req   = {cmd, addr, pbyte, ibyte, present};
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endtask

   // random nonzero byte that is never a bracket, and optionally no opcode
   function automatic logic [BYTE_W-1:0] random_byte(input bit avoid_ops);
      logic [BYTE_W-1:0] b;
      bit clash;
      do begin
         b = 8'($urandom_range(1, 255));
         clash = (b == OP_OPEN) || (b == OP_CLOSE);
         if (avoid_ops)
            clash |= (b == OP_INC) || (b == OP_DEC) || (b == OP_RIGHT) ||
                     (b == OP_LEFT) || (b == OP_OUT) || (b == OP_IN);
      end while (clash);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_op();
      case ($urandom_range(0, 8))
         0:       return OP_INC;
         1:       return OP_DEC;
         2:       return OP_RIGHT;
         3:       return OP_LEFT;
         4:       return OP_OPEN;
         5:       return OP_CLOSE;
         6:       return OP_OUT;
         7:       return OP_IN;
         default: return random_byte(1'b1);
      endcase
   endfunction

   task automatic log_mismatch(input string what, input tape_rsp_type want,
                               input tape_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s: expected out_valid=%0b out_byte=%02h took=%0b halted=%0b pc=%0d, got %s",
                  what, want.out_valid, want.out_byte, want.took_input, want.halted,
                  want.next_pc,
                  $sformatf("out_valid=%0b out_byte=%02h took=%0b halted=%0b pc=%0d",
                            got.out_valid, got.out_byte, got.took_input, got.halted,
                            got.next_pc));
   endtask

   // response side ready, stalled in short bursts
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_chan.ready = 1'b0;
         end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            hold = $urandom_range(0, 2);
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // response check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_rsp = {rsp_chan.out_valid, rsp_chan.out_byte, rsp_chan.took_input,
                    rsp_chan.halted, rsp_chan.next_pc};
         if (due_reports.size() == 0) begin
            log_mismatch("response with nothing outstanding", NO_RSP, got_rsp);
         end else begin
            want_rsp = due_reports.pop_front();
            if (got_rsp.out_valid !== want_rsp.out_valid ||
                got_rsp.out_byte !== want_rsp.out_byte ||
                got_rsp.took_input !== want_rsp.took_input ||
                got_rsp.halted !== want_rsp.halted ||
                got_rsp.next_pc !== want_rsp.next_pc)
               log_mismatch("response mismatch", want_rsp, got_rsp);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bf_tape_interpreter_unit_test failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [BYTE_W-1:0] prog_seq [32];
      logic [BYTE_W-1:0] b;
      int len;
      int n;
      int depth;
      int steps;
      bit broken;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_WRITE;
      req_chan.prog_addr  = '0;
      req_chan.prog_byte  = '0;
      req_chan.in_byte    = '0;
      req_chan.in_present = 1'b0;
      idle_odds      = 4;
      items_done     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      foreach (tape_mem[i]) tape_mem[i] = '0;
      foreach (prog_mem[i]) prog_mem[i] = '0;
      cell_ptr = '0;
      prog_ctr = '0;

      // directed script: idle machine, then one small program walked step by step
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b1, {1'b0, 8'h00, 1'b0, 1'b1, 10'd0});
      add_row(CMD_UNUSED, 10'h3FF, 8'hFF, 8'hFF, 1'b1, 1'b1, {1'b0, 8'h00, 1'b0, 1'b1, 10'd0});
      add_row(CMD_WRITE, 10'd0, OP_LEFT, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd1, OP_RIGHT, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd2, OP_DEC, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd3, OP_CLOSE, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd4, OP_IN, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd5, OP_INC, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd6, OP_OUT, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd7, OP_IN, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd8, OP_OPEN, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd9, OP_CLOSE, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd10, OTHER_BYTE, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_WRITE, 10'd11, OP_OPEN, 8'h00, 1'b0, 1'b0, NO_RSP);
      // pointer wraps low then back, cell wraps down, close with no open below
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      // input taken, increment, output, then input exhausted
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h7F, 1'b1, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'hAA, 1'b0, 1'b0, NO_RSP);
      // forward jump past the match, other byte, open with no match before zero
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP);
      // step while halted, then restart
      add_row(CMD_STEP, 10'd0, 8'h00, 8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b0, 1'b1, 10'd12});
      add_row(CMD_START, 10'd0, 8'h00, 8'h00, 1'b0, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 10'd0});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i])
         send_item(script[i].req, script[i].typed, script[i].want);

      // random programs at address zero, mostly balanced, with noise
      while (items_done < RANDOM_ITEMS) begin
         idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         broken = ($urandom_range(0, 4) == 0);
         len    = $urandom_range(2, 14);
         depth  = 0;
         n      = 0;
         while (n < len) begin
            b = pick_op();
            if (!broken && b == OP_CLOSE && depth == 0)
               b = OP_DEC;
            if (b == OP_OPEN)
               depth++;
            else if (b == OP_CLOSE && depth > 0)
               depth--;
            prog_seq[n] = b;
            n++;
         end
         if (!broken) begin
            while (depth > 0) begin
               prog_seq[n] = OP_CLOSE;
               n++;
               depth--;
            end
         end
         for (int i = 0; i < n; i++)
            issue(CMD_WRITE, 10'(i), prog_seq[i], 1'($urandom_range(0, 1)));
         issue(CMD_WRITE, 10'(n), OP_HALT, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 7) != 0)
            issue(CMD_START, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
         steps = $urandom_range(n, 3 * n + 4);
         repeat (steps) begin
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 2))
                  0: issue(CMD_UNUSED, 10'($urandom), 8'($urandom),
                           1'($urandom_range(0, 1)));
                  1: issue(CMD_WRITE,
                           ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, n))
                                                       : 10'($urandom_range(32, 1023)),
                           8'($urandom), 1'($urandom_range(0, 1)));
                  default: issue(CMD_START, 10'($urandom), 8'($urandom), 1'b0);
               endcase
            end
            issue(CMD_STEP, 10'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
         end
      end

      // whole store filled: long forward scans and program counter wrap
      idle_odds = 0;
      issue(CMD_WRITE, 10'd0, OP_IN, 1'b0);
      issue(CMD_WRITE, 10'd1, OP_OPEN, 1'b0);
      for (int a = 2; a < PROGRAM_BYTES - 2; a++)
         issue(CMD_WRITE, 10'(a), random_byte(1'b0), 1'($urandom_range(0, 1)));
      issue(CMD_WRITE, 10'(PROGRAM_BYTES - 2), OP_CLOSE, 1'b0);
      issue(CMD_WRITE, 10'(PROGRAM_BYTES - 1), OP_OUT, 1'b0);
      issue(CMD_START, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b0);
      // no close anywhere after the open: scan runs off the end
      issue(CMD_WRITE, 10'(PROGRAM_BYTES - 2), random_byte(1'b0), 1'b0);
      issue(CMD_START, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b0);
      issue(CMD_STEP, 10'd0, 8'h00, 1'b1);

      @(negedge clock);
      req_chan.valid = 1'b0;

      // drain and settle
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_reports.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("bf_tape_interpreter_unit_test passed");
      else
         $display("bf_tape_interpreter_unit_test failed");
      $finish;
   end

endmodule
`default_nettype wire
